// ----- design/hvi_pkg.sv -----
package hvi_pkg;

    typedef enum logic [2:0] {
        FN_SPEED_UP   = 3'd0,
        FN_SPEED_DOWN = 3'd1,
        FN_ROT_LEFT   = 3'd2,
        FN_ROT_RIGHT  = 3'd3,
        FN_TICK       = 3'd4,
        FN_TRACK_TICK = 3'd5
    } t_func;

    // angles in 1/1024 degree
    localparam int ANG_W = 13;
    localparam logic [ANG_W-1:0] ANGLE_CLAMP = 13'd3072;
    localparam logic [ANG_W-1:0] ROT_ANGLE   = 13'd5120;

    // degree (1/1024 units) to radians, Q2.30 with 10 extra fraction bits
    localparam logic [24:0] RAD_Q30 = 25'd18740330;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    // series term widths, sized for |angle| <= 5 degrees
    localparam int XW  = 27;
    localparam int X2W = 2 * XW - 30;
    localparam int X3W = X2W + XW - 30;
    localparam int X4W = 2 * X2W - 30;
    localparam int X5W = X4W + XW - 30;

    // reciprocal multipliers: floor(v/d) = (v * M) >> S over the term ranges
    localparam int          DIV6_S   = 29;
    localparam logic [26:0] DIV6_M   = 27'd89478486;
    localparam int          DIV24_S  = 25;
    localparam logic [20:0] DIV24_M  = 21'd1398102;
    localparam int          DIV120_S = 22;
    localparam logic [15:0] DIV120_M = 16'd34953;

endpackage

// ----- design/hvi_ifs.sv -----
interface hvi_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         func;
    logic signed [15:0] tracking_angle;

    modport source(output valid, func, tracking_angle, input ready);
    modport sink(input valid, func, tracking_angle, output ready);
endinterface

interface hvi_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        tick_count;

    modport source(output valid, vel_x, vel_y, pos_x, pos_y, tick_count, input ready);
    modport sink(input valid, vel_x, vel_y, pos_x, pos_y, tick_count, output ready);
endinterface

// ----- design/heading_velocity_integrator_core.sv -----
// A command's result passes through the stage 1 to stage 5 registers and then the state registers that drive o_res.
// Throughput: one command per cycle while o_res.ready does not stall the output; the five sin/cos stages depend only on
// the command, and the state update writes velocity, position and ticks together.
// Reset (i_rst_n low, synchronous): pipeline emptied, velocity set to (0, 1.26),
// position and tick count cleared.
module heading_velocity_integrator_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hvi_cmd_if.sink   i_cmd,
    hvi_res_if.source o_res
);

    localparam int XW  = hvi_pkg::XW;
    localparam int X2W = hvi_pkg::X2W;
    localparam int X3W = hvi_pkg::X3W;
    localparam int X4W = hvi_pkg::X4W;
    localparam int X5W = hvi_pkg::X5W;

    localparam longint K_UP_L   = ((longint'(141) << FRAC_BITS) + 50) / 100;
    localparam longint K_DN_L   = ((longint'(100) << FRAC_BITS) + 70) / 141;
    localparam longint VY_RST_L = ((longint'(126) << FRAC_BITS) + 50) / 100;

    localparam logic signed [63:0] K_UP   = 64'(K_UP_L);
    localparam logic signed [63:0] K_DN   = 64'(K_DN_L);
    localparam logic signed [31:0] VY_RST = 32'(VY_RST_L);
    localparam logic [63:0]        UP_LIM = 64'd22500 << (2 * FRAC_BITS);
    localparam logic [63:0]        DN_LIM = 64'd1 << (2 * FRAC_BITS);

    function automatic logic signed [31:0] rnd_sat(input logic signed [63:0] v,
                                                   input int sh);
        logic [63:0] mag;
        logic [63:0] m;
        mag = v[63] ? 64'(-v) : 64'(v);
        m   = (mag + (64'd1 << (sh - 1))) >> sh;
        if (!v[63]) begin
            rnd_sat = (m > 64'h0000_0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(m);
        end else begin
            rnd_sat = (m > 64'h0000_0000_8000_0000) ? 32'sh8000_0000 : 32'(-m);
        end
    endfunction

    // pipeline flow control
    logic [4:0] r_vld;
    logic [4:0] ld;
    logic       ld_out;
    logic       r_out_vld;

    always_comb begin
        ld_out = !r_out_vld || o_res.ready;
        ld[4]  = !r_vld[4] || ld_out;
        for (int k = 3; k >= 0; k--) begin
            ld[k] = !r_vld[k] || ld[k+1];
        end
    end

    assign i_cmd.ready = ld[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (ld[0]) r_vld[0] <= i_cmd.valid;
            for (int k = 1; k < 5; k++) begin
                if (ld[k]) r_vld[k] <= r_vld[k-1];
            end
            if (ld_out) r_out_vld <= r_vld[4];
        end
    end

    // stage 1: angle select, clamp, degrees to radians
    logic [15:0]                ang_mag;
    logic [hvi_pkg::ANG_W-1:0]  sel_mag;
    logic                       sel_neg;
    logic [37:0]                p_rad;

    always_comb begin
        ang_mag = i_cmd.tracking_angle[15] ? 16'(-i_cmd.tracking_angle)
                                           : 16'(i_cmd.tracking_angle);
        case (hvi_pkg::t_func'(i_cmd.func))
            hvi_pkg::FN_TRACK_TICK: begin
                sel_neg = i_cmd.tracking_angle[15];
                sel_mag = (ang_mag > 16'(hvi_pkg::ANGLE_CLAMP)) ? hvi_pkg::ANGLE_CLAMP
                                                                : ang_mag[hvi_pkg::ANG_W-1:0];
            end
            hvi_pkg::FN_ROT_RIGHT: begin
                sel_neg = 1'b1;
                sel_mag = hvi_pkg::ROT_ANGLE;
            end
            default: begin
                sel_neg = 1'b0;
                sel_mag = hvi_pkg::ROT_ANGLE;
            end
        endcase
        p_rad = 38'(sel_mag) * 38'(hvi_pkg::RAD_Q30) + 38'd512;
    end

    logic [2:0]    r_s1_func;
    logic          r_s1_neg;
    logic [XW-1:0] r_s1_x;

    always_ff @(posedge i_clk) begin
        if (ld[0]) begin
            r_s1_func <= i_cmd.func;
            r_s1_neg  <= sel_neg;
            r_s1_x    <= p_rad[XW+9:10];
        end
    end

    // stage 2: x^2
    logic [2*XW-1:0] p_x2;
    assign p_x2 = (2*XW)'(r_s1_x) * (2*XW)'(r_s1_x);

    logic [2:0]     r_s2_func;
    logic           r_s2_neg;
    logic [XW-1:0]  r_s2_x;
    logic [X2W-1:0] r_s2_x2;

    always_ff @(posedge i_clk) begin
        if (ld[1]) begin
            r_s2_func <= r_s1_func;
            r_s2_neg  <= r_s1_neg;
            r_s2_x    <= r_s1_x;
            r_s2_x2   <= p_x2[2*XW-1:30];
        end
    end

    // stage 3: x^3, x^4
    logic [X2W+XW-1:0] p_x3;
    logic [2*X2W-1:0]  p_x4;
    assign p_x3 = (X2W+XW)'(r_s2_x2) * (X2W+XW)'(r_s2_x);
    assign p_x4 = (2*X2W)'(r_s2_x2) * (2*X2W)'(r_s2_x2);

    logic [2:0]     r_s3_func;
    logic           r_s3_neg;
    logic [XW-1:0]  r_s3_x;
    logic [X2W-1:0] r_s3_x2;
    logic [X3W-1:0] r_s3_x3;
    logic [X4W-1:0] r_s3_x4;

    always_ff @(posedge i_clk) begin
        if (ld[2]) begin
            r_s3_func <= r_s2_func;
            r_s3_neg  <= r_s2_neg;
            r_s3_x    <= r_s2_x;
            r_s3_x2   <= r_s2_x2;
            r_s3_x3   <= p_x3[X2W+XW-1:30];
            r_s3_x4   <= p_x4[2*X2W-1:30];
        end
    end

    // stage 4: x^5, x^2/2, x^3/6, x^4/24
    localparam int Q3P = X3W + 27;
    localparam int Q4P = X4W + 21;
    localparam int Q3W = Q3P - hvi_pkg::DIV6_S;
    localparam int Q4W = Q4P - hvi_pkg::DIV24_S;

    logic [X4W+XW-1:0] p_x5;
    logic [Q3P-1:0]    p_q3;
    logic [Q4P-1:0]    p_q4;
    assign p_x5 = (X4W+XW)'(r_s3_x4) * (X4W+XW)'(r_s3_x);
    assign p_q3 = Q3P'(r_s3_x3) * Q3P'(hvi_pkg::DIV6_M);
    assign p_q4 = Q4P'(r_s3_x4) * Q4P'(hvi_pkg::DIV24_M);

    logic [2:0]       r_s4_func;
    logic             r_s4_neg;
    logic [XW-1:0]    r_s4_x;
    logic [X2W-2:0]   r_s4_q2;
    logic [Q3W-1:0]   r_s4_q3;
    logic [Q4W-1:0]   r_s4_q4;
    logic [X5W-1:0]   r_s4_x5;

    always_ff @(posedge i_clk) begin
        if (ld[3]) begin
            r_s4_func <= r_s3_func;
            r_s4_neg  <= r_s3_neg;
            r_s4_x    <= r_s3_x;
            r_s4_q2   <= r_s3_x2[X2W-1:1];
            r_s4_q3   <= p_q3[Q3P-1:hvi_pkg::DIV6_S];
            r_s4_q4   <= p_q4[Q4P-1:hvi_pkg::DIV24_S];
            r_s4_x5   <= p_x5[X4W+XW-1:30];
        end
    end

    // stage 5: sin, cos
    localparam int Q5P = X5W + 16;

    logic [Q5P-1:0] p_q5;
    logic [XW:0]    sn;
    logic [30:0]    cs;

    always_comb begin
        p_q5 = Q5P'(r_s4_x5) * Q5P'(hvi_pkg::DIV120_M);
        sn   = (XW+1)'(r_s4_x) - (XW+1)'(r_s4_q3)
             + (XW+1)'(p_q5[Q5P-1:hvi_pkg::DIV120_S]);
        cs   = hvi_pkg::ONE_Q30 - 31'(r_s4_q2) + 31'(r_s4_q4);
    end

    logic [2:0]         r_s5_func;
    logic signed [31:0] r_s5_s;
    logic [30:0]        r_s5_c;

    always_ff @(posedge i_clk) begin
        if (ld[4]) begin
            r_s5_func <= r_s4_func;
            r_s5_s    <= r_s4_neg ? -$signed(32'(sn)) : $signed(32'(sn));
            r_s5_c    <= cs;
        end
    end

    // state update
    logic signed [31:0] r_vel_x, r_vel_y, r_pos_x, r_pos_y;
    logic [31:0]        r_ticks;
    logic signed [31:0] n_vel_x, n_vel_y, n_pos_x, n_pos_y;
    logic [31:0]        n_ticks;

    logic signed [63:0] vx64, vy64, c64, s64;
    logic [31:0]        ax, ay;
    logic [63:0]        mag_sq;
    logic signed [31:0] up_x, up_y, dn_x, dn_y, rot_x, rot_y;

    always_comb begin
        vx64   = 64'(r_vel_x);
        vy64   = 64'(r_vel_y);
        c64    = $signed({33'd0, r_s5_c});
        s64    = 64'(r_s5_s);
        ax     = r_vel_x[31] ? 32'(-r_vel_x) : 32'(r_vel_x);
        ay     = r_vel_y[31] ? 32'(-r_vel_y) : 32'(r_vel_y);
        mag_sq = 64'(ax) * 64'(ax) + 64'(ay) * 64'(ay);
        up_x   = rnd_sat(vx64 * K_UP, FRAC_BITS);
        up_y   = rnd_sat(vy64 * K_UP, FRAC_BITS);
        dn_x   = rnd_sat(vx64 * K_DN, FRAC_BITS);
        dn_y   = rnd_sat(vy64 * K_DN, FRAC_BITS);
        rot_x  = rnd_sat(c64 * vx64 + s64 * vy64, 30);
        rot_y  = rnd_sat(c64 * vy64 - s64 * vx64, 30);

        n_vel_x = r_vel_x;
        n_vel_y = r_vel_y;
        n_pos_x = r_pos_x;
        n_pos_y = r_pos_y;
        n_ticks = r_ticks;
        case (hvi_pkg::t_func'(r_s5_func))
            hvi_pkg::FN_SPEED_UP: begin
                if (mag_sq < UP_LIM) begin
                    n_vel_x = up_x;
                    n_vel_y = up_y;
                end
            end
            hvi_pkg::FN_SPEED_DOWN: begin
                if (mag_sq > DN_LIM) begin
                    n_vel_x = dn_x;
                    n_vel_y = dn_y;
                end
            end
            hvi_pkg::FN_ROT_LEFT, hvi_pkg::FN_ROT_RIGHT: begin
                n_vel_x = rot_x;
                n_vel_y = rot_y;
            end
            hvi_pkg::FN_TICK: begin
                n_pos_x = r_pos_x + r_vel_x;
                n_pos_y = r_pos_y + r_vel_y;
                n_ticks = r_ticks + 32'd1;
            end
            hvi_pkg::FN_TRACK_TICK: begin
                n_vel_x = rot_x;
                n_vel_y = rot_y;
                n_pos_x = r_pos_x + rot_x;
                n_pos_y = r_pos_y + rot_y;
                n_ticks = r_ticks + 32'd1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vel_x <= '0;
            r_vel_y <= VY_RST;
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_ticks <= '0;
        end else if (ld_out && r_vld[4]) begin
            r_vel_x <= n_vel_x;
            r_vel_y <= n_vel_y;
            r_pos_x <= n_pos_x;
            r_pos_y <= n_pos_y;
            r_ticks <= n_ticks;
        end
    end

    assign o_res.valid      = r_out_vld;
    assign o_res.vel_x      = r_vel_x;
    assign o_res.vel_y      = r_vel_y;
    assign o_res.pos_x      = r_pos_x;
    assign o_res.pos_y      = r_pos_y;
    assign o_res.tick_count = r_ticks;

endmodule
